// File: design/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, register indexes, reset values and types of the PID step core.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // Field widths.
  localparam int SAMPLE_W   = 16;
  localparam int ERR_W      = 17;
  localparam int GAIN_W     = 16;
  localparam int DRIVE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Fixed-point formats: the integral keeps eight fraction bits.
  localparam int INTEG_FRAC_BITS     = 8;
  localparam int GAIN_FRAC_BITS_DEF  = 8;
  localparam int ACC_W               = DRIVE_W + INTEG_FRAC_BITS;
  localparam int PROD_W              = ERR_W + GAIN_W;
  // A gain term in integral format; wide enough for the largest left shift.
  localparam int TERM_W              = PROD_W + INTEG_FRAC_BITS;
  localparam int SUM_W               = TERM_W + 1;
  localparam int TOTAL_W             = TERM_W + 2;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX    = 3'd5;

  // Configuration register file.
  typedef struct packed {
    logic signed [CFG_DATA_W-1:0] setpoint;
    logic signed [CFG_DATA_W-1:0] prop_gain;
    logic signed [CFG_DATA_W-1:0] integ_gain;
    logic signed [CFG_DATA_W-1:0] deriv_gain;
    logic signed [CFG_DATA_W-1:0] out_min;
    logic signed [CFG_DATA_W-1:0] out_max;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    setpoint:   16'h0000,
    prop_gain:  16'h0000,
    integ_gain: 16'h0000,
    deriv_gain: 16'h0000,
    out_min:    16'h8000,
    out_max:    16'h7FFF
  };

  // One classified step travelling from the front part to the back part.
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [TERM_W-1:0] p_term;
    logic signed [TERM_W-1:0] i_term;
    logic signed [TERM_W-1:0] d_term;
  } work_item_t;

endpackage

// File: design/pidc_front.sv
// ----------------------------------------------------------------------------
// pidc_front
// Accepts samples, forms error and derivative, and the three gain products.
// ----------------------------------------------------------------------------
module pidc_front #(
  parameter int GAIN_FRAC_BITS = pidc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pidc_pkg::cfg_regs_t                  cfg,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pidc_pkg::SAMPLE_W-1:0] sample,
  output logic                                 push,
  output pidc_pkg::work_item_t                 push_item,
  input  logic                                 queue_full
);
  import pidc_pkg::*;

  // Shift that brings a gain product to the integral format.
  localparam int RSH = (GAIN_FRAC_BITS >= INTEG_FRAC_BITS) ?
                       GAIN_FRAC_BITS - INTEG_FRAC_BITS : 0;
  localparam int LSH = (GAIN_FRAC_BITS < INTEG_FRAC_BITS) ?
                       INTEG_FRAC_BITS - GAIN_FRAC_BITS : 0;

  logic                       s1_valid;
  logic signed [ERR_W-1:0]    s1_err;
  logic signed [ERR_W-1:0]    s1_deriv;
  logic signed [SAMPLE_W-1:0] last_sample;
  logic                       s2_valid;
  logic signed [ERR_W-1:0]    s2_err;
  logic signed [PROD_W-1:0]   s2_p_prod;
  logic signed [PROD_W-1:0]   s2_i_prod;
  logic signed [PROD_W-1:0]   s2_d_prod;
  logic                       s1_ready;
  logic                       s2_ready;
  logic                       accept;

  // Each stage moves on when the one after it has room.
  assign s2_ready = !s2_valid || !queue_full;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;
  assign accept   = in_valid && s1_ready;
  assign push     = s2_valid && !queue_full;

  // Stage one: error and derivative on the measurement.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      last_sample <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (accept) begin
        last_sample <= sample;
      end
    end
    if (accept) begin
      s1_err   <= {cfg.setpoint[CFG_DATA_W-1], cfg.setpoint} - {sample[SAMPLE_W-1], sample};
      s1_deriv <= {sample[SAMPLE_W-1], sample} - {last_sample[SAMPLE_W-1], last_sample};
    end
  end

  // Stage two: the three gain products, each registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s1_valid && s2_ready) begin
      s2_err    <= s1_err;
      s2_p_prod <= $signed(cfg.prop_gain) * s1_err;
      s2_i_prod <= $signed(cfg.integ_gain) * s1_err;
      s2_d_prod <= $signed(cfg.deriv_gain) * s1_deriv;
    end
  end

  // Bring the products to the integral format; flooring by arithmetic shift.
  always_comb begin
    push_item.err    = s2_err;
    push_item.p_term = (TERM_W'(s2_p_prod) >>> RSH) <<< LSH;
    push_item.i_term = (TERM_W'(s2_i_prod) >>> RSH) <<< LSH;
    push_item.d_term = (TERM_W'(s2_d_prod) >>> RSH) <<< LSH;
  end

endmodule

// File: design/pidc_queue.sv
// ----------------------------------------------------------------------------
// pidc_queue
// Short first-in first-out queue of work items between front and back parts.
// ----------------------------------------------------------------------------
module pidc_queue #(
  parameter int DEPTH = pidc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pidc_pkg::work_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output pidc_pkg::work_item_t pop_item,
  output logic                 not_empty
);
  import pidc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_item_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = entries[rd_ptr];

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// File: design/pidc_back.sv
// ----------------------------------------------------------------------------
// pidc_back
// Updates the clamped integral, sums the drive and holds the result register.
// ----------------------------------------------------------------------------
module pidc_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pidc_pkg::cfg_regs_t                  cfg,
  input  logic                                 not_empty,
  input  pidc_pkg::work_item_t                 pop_item,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pidc_pkg::DRIVE_W-1:0]  drive,
  output logic signed [pidc_pkg::ERR_W-1:0]    error
);
  import pidc_pkg::*;

  localparam int SHIFTED_W = TOTAL_W - INTEG_FRAC_BITS;

  logic signed [ACC_W-1:0]      integral_acc;
  logic signed [GAIN_W-1:0]     last_integ_gain;
  logic signed [ACC_W-1:0]      integ_base;
  logic signed [SUM_W-1:0]      integ_sum;
  logic signed [SUM_W-1:0]      hi8;
  logic signed [SUM_W-1:0]      lo8;
  logic signed [ACC_W-1:0]      integ_next;
  logic signed [TOTAL_W-2:0]    pd_diff;
  logic                         b1_valid;
  logic signed [ACC_W-1:0]      b1_integ;
  logic signed [TOTAL_W-2:0]    b1_pd;
  logic signed [ERR_W-1:0]      b1_err;
  logic signed [TOTAL_W-1:0]    total;
  logic signed [SHIFTED_W-1:0]  shifted;
  logic signed [SHIFTED_W-1:0]  lim_hi;
  logic signed [SHIFTED_W-1:0]  lim_lo;
  logic signed [DRIVE_W-1:0]    drive_next;
  logic                         b1_ready;
  logic                         b2_ready;

  // Hand-off between the two back stages and the result register.
  assign b2_ready = !out_valid || !out_stall;
  assign b1_ready = !b1_valid || b2_ready;
  assign pop      = not_empty && b1_ready;

  // Integral update: cleared on a gain change, then accumulated and clamped.
  // With inverted limits, a sum above the upper limit takes it and any other sum the lower.
  always_comb begin
    integ_base = (last_integ_gain != cfg.integ_gain) ? '0 : integral_acc;
    integ_sum  = SUM_W'(integ_base) + SUM_W'(pop_item.i_term);
    hi8        = SUM_W'($signed({cfg.out_max, {INTEG_FRAC_BITS{1'b0}}}));
    lo8        = SUM_W'($signed({cfg.out_min, {INTEG_FRAC_BITS{1'b0}}}));
    if (integ_sum > hi8) begin
      integ_next = hi8[ACC_W-1:0];
    end else if (integ_sum < lo8) begin
      integ_next = lo8[ACC_W-1:0];
    end else begin
      integ_next = integ_sum[ACC_W-1:0];
    end
    pd_diff = (TOTAL_W - 1)'(pop_item.p_term) - (TOTAL_W - 1)'(pop_item.d_term);
  end

  // First back stage: integral state and proportional minus derivative.
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid        <= 1'b0;
      integral_acc    <= '0;
      last_integ_gain <= '0;
    end else begin
      if (b1_ready) begin
        b1_valid <= not_empty;
      end
      if (pop) begin
        integral_acc    <= integ_next;
        last_integ_gain <= cfg.integ_gain;
      end
    end
    if (pop) begin
      b1_integ <= integ_next;
      b1_pd    <= pd_diff;
      b1_err   <= pop_item.err;
    end
  end

  // Drive sum, floored to an integer and clamped like the integral.
  always_comb begin
    total   = TOTAL_W'(b1_pd) + TOTAL_W'(b1_integ);
    shifted = SHIFTED_W'(total >>> INTEG_FRAC_BITS);
    lim_hi  = SHIFTED_W'(cfg.out_max);
    lim_lo  = SHIFTED_W'(cfg.out_min);
    if (shifted > lim_hi) begin
      drive_next = cfg.out_max;
    end else if (shifted < lim_lo) begin
      drive_next = cfg.out_min;
    end else begin
      drive_next = shifted[DRIVE_W-1:0];
    end
  end

  // Result register; it holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b2_ready) begin
      out_valid <= b1_valid;
    end
    if (b1_valid && b2_ready) begin
      drive <= drive_next;
      error <= b1_err;
    end
  end

endmodule

// File: design/pid_controller_step_core.sv
// ----------------------------------------------------------------------------
// pid_controller_step_core
// Fixed-point PID controller step with derivative taken on the measurement.
// ----------------------------------------------------------------------------
// Usage:
// A sample enters on the input channel when in_valid is high and in_stall is
// low; each sample yields one transaction on the output channel carrying the
// clamped drive and the error (setpoint minus sample).
// Configuration registers are written through cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high and indexes beyond out_max are ignored. Write them
// only while no step is in flight.
// A sample passes the error, product, queue, integral and result registers.
// Throughput is one sample per cycle when unstalled: front stages (error,
// then three multipliers) and back stages (integral update, then drive sum)
// each take one item a cycle; integral feedback closes in a single back stage.
// When the receiver stalls, the result register holds, the back part stops,
// and the queue between the parts absorbs up to its depth before in_stall
// rises. Reset clears the integral, the previous sample and the remembered
// integral gain, empties all stages and restores the register defaults.
// ----------------------------------------------------------------------------
module pid_controller_step_core #(
  parameter int GAIN_FRAC_BITS = pidc_pkg::GAIN_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH    = pidc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [pidc_pkg::SAMPLE_W-1:0]   sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [pidc_pkg::DRIVE_W-1:0]    drive,
  output logic signed [pidc_pkg::ERR_W-1:0]      error,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import pidc_pkg::*;

  cfg_regs_t  cfg;
  logic       push;
  work_item_t push_item;
  logic       queue_full;
  logic       pop;
  work_item_t pop_item;
  logic       not_empty;

  // Configuration register file; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SETPOINT:   cfg.setpoint   <= cfg_data;
        REG_PROP_GAIN:  cfg.prop_gain  <= cfg_data;
        REG_INTEG_GAIN: cfg.integ_gain <= cfg_data;
        REG_DERIV_GAIN: cfg.deriv_gain <= cfg_data;
        REG_OUT_MIN:    cfg.out_min    <= cfg_data;
        REG_OUT_MAX:    cfg.out_max    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front part: accepts and prepares each step.
  pidc_front #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  // Queue decoupling the two parts.
  pidc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (not_empty)
  );

  // Back part: integral, drive and result register.
  pidc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .not_empty (not_empty),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive     (drive),
    .error     (error)
  );

endmodule

// File: design/pidc_checker.sv
// ----------------------------------------------------------------------------
// pidc_checker
// Port-level checks of the PID step core, bound to the top level.
// ----------------------------------------------------------------------------
module pidc_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [pidc_pkg::DRIVE_W-1:0]  drive,
  input logic signed [pidc_pkg::ERR_W-1:0]    error,
  input logic                                 cfg_ready
);
  import pidc_pkg::*;

  // A stalled result stays offered.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  // A stalled result keeps its payload.
  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(drive) && $stable(error))
    else $error("result payload changed while stalled");

  // Reset empties every stage, so nothing is offered and samples are taken.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // The register port never pushes back.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind pid_controller_step_core pidc_checker u_pidc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .drive     (drive),
  .error     (error),
  .cfg_ready (cfg_ready)
);
